// File: src/manchester_packet_receiver_assert.svh
// assertion macros for the manchester packet receiver
// used by modules that check their own control logic; needs clk and rst_n in scope
`ifndef MANCHESTER_PACKET_RECEIVER_ASSERT_SVH
`define MANCHESTER_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication
`define MPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpr assertion failed");

// next-cycle implication
`define MPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpr assertion failed");

`endif

// File: src/mpr_pkg.sv
// shared types and constants for the manchester packet receiver
// no dependencies
`default_nettype none

package mpr_pkg;

  localparam logic [7:0] PREAMBLE_BYTE  = 8'hFE;

  localparam logic [7:0] SHORT_MIN_RST  = 8'd26;
  localparam logic [7:0] LONG_MIN_RST   = 8'd78;
  localparam logic [7:0] LONG_MAX_RST   = 8'd130;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd255;

  localparam logic [1:0] REG_SHORT_MIN  = 2'd0;
  localparam logic [1:0] REG_LONG_MIN   = 2'd1;
  localparam logic [1:0] REG_LONG_MAX   = 2'd2;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd3;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef enum logic [3:0] {
    ST_HUNT = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_DATA = 4'b0100,
    ST_CHK  = 4'b1000
  } stage_t;

  typedef struct packed {
    logic [7:0] short_min;
    logic [7:0] long_min;
    logic [7:0] long_max;
  } timing_cfg_t;

  typedef struct packed {
    logic valid;
    logic level;
  } bit_evt_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// File: src/mpr_front.sv
// front end: classifies transition intervals and tracks the half-bit phase
// depends on mpr_pkg
`default_nettype none

module mpr_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       accept,
  input  wire  [7:0]                interval,
  input  wire                       level,
  input  wire mpr_pkg::timing_cfg_t cfg,
  output mpr_pkg::bit_evt_t         evt
);
  import mpr_pkg::*;

  logic phase_r, phase_nxt;
  logic take;

  always_comb begin
    phase_nxt = phase_r;
    take      = 1'b0;
    if (accept) begin
      priority if (interval < cfg.short_min) begin
        phase_nxt = 1'b0;
      end else if (interval < cfg.long_min) begin
        take      = phase_r;
        phase_nxt = ~phase_r;
      end else if (interval < cfg.long_max) begin
        take      = ~phase_r;
        phase_nxt = 1'b0;
      end else begin
        // interval too long, ignored
        take      = 1'b0;
      end
    end
  end

  assign evt.valid = take;
  assign evt.level = level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/mpr_bitq.sv
// four-entry queue of sampled bits between front end and framer
// depends on mpr_pkg
`default_nettype none

module mpr_bitq (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire mpr_pkg::bit_evt_t push_evt,
  input  wire                    pop,
  output logic                   dout,
  output logic                   full,
  output logic                   empty
);
  import mpr_pkg::*;

  logic       mem_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign do_push = push_evt.valid & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_evt.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: src/mpr_back.sv
// back end: assembles bytes, frames packets and queues result items
// depends on mpr_pkg and the assertion macro header
`default_nettype none
`include "manchester_packet_receiver_assert.svh"

module mpr_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              bit_avail,
  input  wire              bit_level,
  input  wire  [7:0]       max_length,
  input  wire              out_pop,
  output logic             bit_pop,
  output mpr_pkg::result_t out_res,
  output logic             out_empty
);
  import mpr_pkg::*;

  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt, shift_set;
  stage_t     stage_r, stage_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] count_r, count_nxt, count_inc;
  logic [7:0] xor_r, xor_nxt;
  logic       byte_done;
  logic       res_push;
  result_t    res;

  result_t    oq_r [2];
  logic       oq_wr_r, oq_rd_r;
  logic [1:0] oq_cnt_r;
  logic       oq_pop;

  assign oq_pop    = out_pop & (oq_cnt_r != 2'd0);
  assign bit_pop   = bit_avail & ((oq_cnt_r != 2'd2) | oq_pop);
  assign byte_done = (bit_cnt_r == 3'd7);
  assign count_inc = count_r + 8'd1;

  always_comb begin
    shift_set            = shift_r;
    shift_set[bit_cnt_r] = bit_level;
  end

  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    stage_nxt   = stage_r;
    len_nxt     = len_r;
    count_nxt   = count_r;
    xor_nxt     = xor_r;
    res_push    = 1'b0;
    res         = '{kind: KIND_DATA, byte_value: shift_set, byte_index: count_r, last: 1'b0};
    if (bit_pop) begin
      shift_nxt   = shift_set;
      bit_cnt_nxt = bit_cnt_r + 3'd1;
      if (byte_done) begin
        unique case (stage_r)
          ST_HUNT: begin
            if (shift_set == PREAMBLE_BYTE) begin
              stage_nxt = ST_LEN;
              xor_nxt   = '0;
              count_nxt = '0;
            end
          end
          ST_LEN: begin
            if (shift_set > max_length) begin
              stage_nxt = ST_HUNT;
            end else begin
              len_nxt   = shift_set;
              xor_nxt   = xor_r ^ shift_set;
              stage_nxt = (shift_set == 8'd0) ? ST_CHK : ST_DATA;
            end
          end
          ST_DATA: begin
            res_push  = 1'b1;
            xor_nxt   = xor_r ^ shift_set;
            count_nxt = count_inc;
            if (count_inc >= len_r) stage_nxt = ST_CHK;
          end
          ST_CHK: begin
            res_push  = 1'b1;
            res.kind  = ((xor_r ^ shift_set) == 8'd0) ? KIND_GOOD : KIND_BAD;
            res.last  = 1'b1;
            stage_nxt = ST_HUNT;
          end
          default: begin
            stage_nxt = ST_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      shift_r   <= '0;
      stage_r   <= ST_HUNT;
      len_r     <= '0;
      count_r   <= '0;
      xor_r     <= '0;
    end else begin
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      stage_r   <= stage_nxt;
      len_r     <= len_nxt;
      count_r   <= count_nxt;
      xor_r     <= xor_nxt;
    end
  end

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      if (res_push) oq_wr_r <= ~oq_wr_r;
      if (oq_pop)   oq_rd_r <= ~oq_rd_r;
      oq_cnt_r <= oq_cnt_r + 2'(res_push) - 2'(oq_pop);
    end
  end

  assign out_res   = oq_r[oq_rd_r];
  assign out_empty = (oq_cnt_r == 2'd0);

  `MPR_ASSERT_NOW(a_oq_bound, 1'b1, oq_cnt_r != 2'd3)
  `MPR_ASSERT_NOW(a_push_room, res_push, (oq_cnt_r != 2'd2) || oq_pop)
  `MPR_ASSERT_NEXT(a_verdict_hunt, bit_pop && byte_done && (stage_r == ST_CHK),
                   stage_r == ST_HUNT)
  `MPR_ASSERT_NEXT(a_preamble_clear,
                   bit_pop && byte_done && (stage_r == ST_HUNT) && (shift_set == PREAMBLE_BYTE),
                   (count_r == 8'd0) && (xor_r == 8'd0) && (stage_r == ST_LEN))

endmodule

`default_nettype wire

// File: src/manchester_packet_receiver.sv
// top level of the manchester packet receiver: configuration registers and wiring
// depends on mpr_pkg, mpr_front, mpr_bitq and mpr_back
`default_nettype none

// Takes one line transition item per cycle while in_full is low and delivers
// decoded data bytes and packet verdicts through a result queue. The front end
// classifies each interval in the same cycle it is accepted; sampled bits pass
// through a four-entry bit queue to the framer, which handles one bit per cycle
// while the output queue has room or is popped, and writes results into a
// two-entry output queue; the completing bit is registered in the bit queue and
// the result in the output queue before it shows on the out_ ports. in_full rises
// only when results are left waiting on out_pop long enough for the bit queue to
// fill. Interval compares use the low INTERVAL_BITS bits (at most 8) of the interval and of the timing thresholds.
module manchester_packet_receiver #(
  parameter int INTERVAL_BITS = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  output logic        in_full,
  input  wire  [7:0]  in_interval_ticks,
  input  wire         in_line_level,
  output logic        out_empty,
  input  wire         out_pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte_value,
  output logic [7:0]  out_byte_index,
  output logic        out_last,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpr_pkg::*;

  localparam int         CMP_W   = (INTERVAL_BITS < 8) ? INTERVAL_BITS : 8;
  localparam logic [7:0] IV_MASK = 8'((1 << CMP_W) - 1);

  logic [7:0]  short_min_r, long_min_r, long_max_r, max_length_r;
  logic        wr_en;
  logic [1:0]  reg_idx;
  timing_cfg_t tcfg;
  bit_evt_t    evt;
  logic        in_accept;
  logic        bq_dout, bq_empty, bit_pop;
  result_t     res;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_min_r  <= SHORT_MIN_RST;
      long_min_r   <= LONG_MIN_RST;
      long_max_r   <= LONG_MAX_RST;
      max_length_r <= MAX_LENGTH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SHORT_MIN:  short_min_r  <= pwdata[7:0];
        REG_LONG_MIN:   long_min_r   <= pwdata[7:0];
        REG_LONG_MAX:   long_max_r   <= pwdata[7:0];
        REG_MAX_LENGTH: max_length_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHORT_MIN:  prdata = {24'd0, short_min_r};
      REG_LONG_MIN:   prdata = {24'd0, long_min_r};
      REG_LONG_MAX:   prdata = {24'd0, long_max_r};
      REG_MAX_LENGTH: prdata = {24'd0, max_length_r};
      default:        prdata = '0;
    endcase
  end

  assign tcfg.short_min = short_min_r & IV_MASK;
  assign tcfg.long_min  = long_min_r & IV_MASK;
  assign tcfg.long_max  = long_max_r & IV_MASK;

  assign in_accept = in_push & ~in_full;

  mpr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .interval (in_interval_ticks & IV_MASK),
    .level    (in_line_level),
    .cfg      (tcfg),
    .evt      (evt)
  );

  mpr_bitq u_bitq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_evt (evt),
    .pop      (bit_pop),
    .dout     (bq_dout),
    .full     (in_full),
    .empty    (bq_empty)
  );

  mpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bit_avail  (~bq_empty),
    .bit_level  (bq_dout),
    .max_length (max_length_r),
    .out_pop    (out_pop),
    .bit_pop    (bit_pop),
    .out_res    (res),
    .out_empty  (out_empty)
  );

  assign out_kind       = res.kind;
  assign out_byte_value = res.byte_value;
  assign out_byte_index = res.byte_index;
  assign out_last       = res.last;

endmodule

`default_nettype wire

// File: tb/manchester_packet_receiver_tb.sv
`timescale 1ns / 100ps
// testbench for manchester_packet_receiver: line transitions in, decoded bytes and verdicts out
// needs mpr_pkg and the receiver rtl; predicts each result and checks it field by field
module manchester_packet_receiver_tb;
  import mpr_pkg::*;

  localparam int QUIET_LIMIT = 600;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [1:0] REG_ORDER [4] = '{REG_SHORT_MIN, REG_LONG_MIN, REG_LONG_MAX,
                                           REG_MAX_LENGTH};
  localparam logic [7:0] BOUNDARY_TICKS [20] = '{8'd0, 8'd25, 8'd26, 8'd77, 8'd78, 8'd129,
                                                 8'd130, 8'd255, 8'd26, 8'd26, 8'd26, 8'd77,
                                                 8'd78, 8'd78, 8'd129, 8'd130, 8'd255, 8'd25,
                                                 8'd26, 8'd77};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_interval_ticks = 8'h00;
  logic        in_line_level = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte_value;
  logic [7:0]  out_byte_index;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  manchester_packet_receiver uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_interval_ticks(in_interval_ticks), .in_line_level(in_line_level),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_kind(out_kind), .out_byte_value(out_byte_value),
    .out_byte_index(out_byte_index), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder model state
  logic [7:0] timing_reg [4];
  logic       mid_bit = 1'b0;
  logic [2:0] bits_taken = 3'd0;
  logic [7:0] assembling = 8'h00;
  stage_t     frame_stage = ST_HUNT;
  logic [7:0] frame_len = 8'h00;
  logic [7:0] frame_count = 8'h00;
  logic [7:0] frame_xor = 8'h00;
  result_t    awaited_results [$];

  int mismatches = 0;
  int items_sent = 0;
  int idle_odds = 0;
  int stall_odds = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic void frame_byte(logic [7:0] b);
    result_t r;
    case (frame_stage)
      ST_HUNT: begin
        if (b == PREAMBLE_BYTE) begin
          frame_stage = ST_LEN;
          frame_xor = 8'h00;
          frame_count = 8'h00;
        end
      end
      ST_LEN: begin
        if (b > timing_reg[REG_MAX_LENGTH]) begin
          frame_stage = ST_HUNT;
        end else begin
          frame_len = b;
          frame_xor ^= b;
          frame_stage = (b == 8'h00) ? ST_CHK : ST_DATA;
        end
      end
      ST_DATA: begin
        r.kind = KIND_DATA;
        r.byte_value = b;
        r.byte_index = frame_count;
        r.last = 1'b0;
        awaited_results.push_back(r);
        frame_xor ^= b;
        frame_count++;
        if (frame_count >= frame_len) frame_stage = ST_CHK;
      end
      default: begin
        r.kind = (frame_xor == b) ? KIND_GOOD : KIND_BAD;
        r.byte_value = b;
        r.byte_index = frame_count;
        r.last = 1'b1;
        awaited_results.push_back(r);
        frame_stage = ST_HUNT;
      end
    endcase
  endfunction

  function automatic void sample_bit(logic level);
    assembling[bits_taken] = level;
    if (bits_taken != 3'd7) begin
      bits_taken++;
    end else begin
      bits_taken = 3'd0;
      frame_byte(assembling);
    end
  endfunction

  function automatic void decode_transition(logic [7:0] ticks, logic level);
    if (ticks < timing_reg[REG_SHORT_MIN]) begin
      mid_bit = 1'b0;
    end else if (ticks < timing_reg[REG_LONG_MIN]) begin
      if (mid_bit) sample_bit(level);
      mid_bit = ~mid_bit;
    end else if (ticks < timing_reg[REG_LONG_MAX]) begin
      if (!mid_bit) sample_bit(level);
      else mid_bit = 1'b0;
    end
  endfunction

  function automatic logic short_ok();
    return timing_reg[REG_SHORT_MIN] < timing_reg[REG_LONG_MIN];
  endfunction

  function automatic logic [7:0] long_floor();
    return (timing_reg[REG_SHORT_MIN] > timing_reg[REG_LONG_MIN]) ?
           timing_reg[REG_SHORT_MIN] : timing_reg[REG_LONG_MIN];
  endfunction

  function automatic logic long_ok();
    return long_floor() < timing_reg[REG_LONG_MAX];
  endfunction

  function automatic logic [7:0] pick_short();
    return 8'($urandom_range(timing_reg[REG_LONG_MIN] - 1, timing_reg[REG_SHORT_MIN]));
  endfunction

  function automatic logic [7:0] pick_long();
    return 8'($urandom_range(timing_reg[REG_LONG_MAX] - 1, long_floor()));
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: random pop stalls and the scoreboard
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_pop <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, got kind %0d value %0d index %0d last %0d",
                 $time, out_kind, out_byte_value, out_byte_index, out_last);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("byte_value", want.byte_value, out_byte_value);
        check_field("byte_index", want.byte_index, out_byte_index);
        check_field("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d items outstanding", $time, QUIET_LIMIT,
               awaited_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_transition(input logic [7:0] ticks, input logic level);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_interval_ticks <= ticks;
    in_line_level <= level;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    decode_transition(ticks, level);
  endtask

  // one bit as a full-bit interval or a pair of half-bit intervals, phase clear on entry
  task automatic send_bit(input logic level);
    logic [7:0] top;
    if ($urandom_range(0, 23) == 0) begin
      top = (long_floor() > timing_reg[REG_LONG_MAX]) ? long_floor() : timing_reg[REG_LONG_MAX];
      send_transition(8'($urandom_range(255, top)), 1'($urandom_range(0, 1)));
    end
    if (long_ok() && (!short_ok() || $urandom_range(0, 1) == 1)) begin
      send_transition(pick_long(), level);
    end else begin
      send_transition(pick_short(), 1'($urandom_range(0, 1)));
      send_transition(pick_short(), level);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    for (int k = 0; k < 8; k++) send_bit(b[k]);
  endtask

  // realigns to a byte boundary in the hunt, then sends one frame, cut short if 0 <= cut < its size
  task automatic send_packet(input logic [7:0] len, input logic [7:0] sum_flip, input int cut);
    logic [7:0] frame_bytes [$];
    logic [7:0] sum;
    logic [7:0] d;
    int n;
    if (mid_bit) begin
      if (timing_reg[REG_SHORT_MIN] != 8'h00)
        send_transition(8'($urandom_range(timing_reg[REG_SHORT_MIN] - 1, 0)),
                        1'($urandom_range(0, 1)));
      else if (long_ok())
        send_transition(pick_long(), 1'($urandom_range(0, 1)));
      else
        send_transition(pick_short(), 1'($urandom_range(0, 1)));
    end
    while (bits_taken != 3'd0) send_bit(1'($urandom_range(0, 1)));
    while (frame_stage != ST_HUNT) send_byte(8'h00);
    frame_bytes.push_back(PREAMBLE_BYTE);
    frame_bytes.push_back(len);
    sum = len;
    repeat (len) begin
      d = 8'($urandom);
      frame_bytes.push_back(d);
      sum ^= d;
    end
    frame_bytes.push_back(sum ^ sum_flip);
    n = (cut < 0 || cut > frame_bytes.size()) ? frame_bytes.size() : cut;
    for (int k = 0; k < n; k++) send_byte(frame_bytes[k]);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [7:0] data,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, data};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    logic [31:0] unused;
    apb_access(idx, 1'b1, value, unused);
    timing_reg[idx] = value;
  endtask

  task automatic verify_registers();
    logic [31:0] rd;
    foreach (REG_ORDER[k]) begin
      apb_access(REG_ORDER[k], 1'b0, 8'h00, rd);
      check_field("register", {24'h0, timing_reg[REG_ORDER[k]]}, rd);
    end
  endtask

  task automatic program_timing(input logic [7:0] s_min, input logic [7:0] l_min,
                                input logic [7:0] l_max, input logic [7:0] len_cap);
    wait_drained();
    write_reg(REG_SHORT_MIN, s_min);
    write_reg(REG_LONG_MIN, l_min);
    write_reg(REG_LONG_MAX, l_max);
    write_reg(REG_MAX_LENGTH, len_cap);
    verify_registers();
  endtask

  task automatic random_traffic(input int budget);
    int start;
    logic [7:0] len;
    start = items_sent;
    while (items_sent - start < budget) begin
      len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(20, 6)) : 8'($urandom_range(5, 0));
      send_packet(len, ($urandom_range(0, 4) == 0) ? 8'($urandom_range(255, 1)) : 8'h00,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(len + 2, 0) : -1);
      if ($urandom_range(0, 9) == 0)
        send_transition(8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_register_reset();
    verify_registers();
  endtask

  task automatic test_interval_edges();
    foreach (BOUNDARY_TICKS[k])
      send_transition(BOUNDARY_TICKS[k], 1'(k[0] ^ k[2]));
  endtask

  task automatic test_packet_framing();
    send_packet(8'd3, 8'h00, -1);
    send_packet(8'd0, 8'h00, -1);
    send_packet(8'd2, 8'h5A, -1);
    wait_drained();
    send_byte(8'h7E);
    send_byte(8'hFF);
    send_packet(8'd1, 8'h00, -1);
    send_packet(8'd6, 8'h00, 4);
    send_packet(8'd8, 8'h00, -1);
    program_timing(SHORT_MIN_RST, LONG_MIN_RST, LONG_MAX_RST, 8'd4);
    send_packet(8'd5, 8'h00, -1);
    send_packet(8'd4, 8'h00, -1);
    send_packet(8'd0, 8'h01, -1);
  endtask

  task automatic test_threshold_sweep();
    program_timing(SHORT_MIN_RST, LONG_MIN_RST, LONG_MAX_RST, MAX_LENGTH_RST);
    random_traffic(60);
    program_timing(8'd0, 8'd1, 8'd255, 8'd0);
    random_traffic(40);
    program_timing(8'd100, 8'd180, 8'd255, 8'd8);
    random_traffic(60);
    program_timing(8'd1, 8'd2, 8'd3, 8'd255);
    random_traffic(40);
    program_timing(8'd200, 8'd100, 8'd250, 8'd6);
    random_traffic(40);
  endtask

  task automatic test_line_noise();
    program_timing(8'd200, 8'd100, 8'd50, 8'd3);
    repeat (30) send_transition(8'($urandom), 1'($urandom_range(0, 1)));
    program_timing(8'd0, 8'd0, 8'd0, 8'd255);
    repeat (20) send_transition(8'($urandom), 1'($urandom_range(0, 1)));
    program_timing(8'd255, 8'd255, 8'd255, 8'd0);
    repeat (20) send_transition(8'($urandom), 1'($urandom_range(0, 1)));
    program_timing(8'd0, 8'd255, 8'd255, 8'd255);
    repeat (30) send_transition(8'($urandom), 1'($urandom_range(0, 1)));
    program_timing(SHORT_MIN_RST, LONG_MIN_RST, LONG_MAX_RST, MAX_LENGTH_RST);
    repeat (30) send_transition(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_quiet_tail();
    program_timing(SHORT_MIN_RST, LONG_MIN_RST, LONG_MAX_RST, MAX_LENGTH_RST);
    idle_odds = 0;
    stall_odds = 0;
    random_traffic(80);
  endtask

  initial begin
    timing_reg[REG_SHORT_MIN] = SHORT_MIN_RST;
    timing_reg[REG_LONG_MIN] = LONG_MIN_RST;
    timing_reg[REG_LONG_MAX] = LONG_MAX_RST;
    timing_reg[REG_MAX_LENGTH] = MAX_LENGTH_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_odds = 6;
    stall_odds = 6;
    test_register_reset();
    test_interval_edges();
    test_packet_framing();
    test_threshold_sweep();
    test_line_noise();
    test_quiet_tail();
    wait_drained();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
